[rtl/alkd_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// alkd_pkg: shared types and constants of the ladder keypad debouncer
// Register map, reset values, default parameters and the key event beat.
// ---------------------------------------------------------------------------
package alkd_pkg;

    // default build parameters
    localparam int DEF_HISTORY_DEPTH = 5;
    localparam int DEF_SAMPLE_BITS   = 12;

    // field widths
    localparam int LEVEL_W = 12;
    localparam int VOTE_W  = 3;
    localparam int KEY_W   = 2;

    // APB port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    // register indexes (byte address = 4 * index)
    localparam logic [IDX_W-1:0] REG_LEVEL_ONE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_LEVEL_TWO   = 3'd1;
    localparam logic [IDX_W-1:0] REG_LEVEL_THREE = 3'd2;
    localparam logic [IDX_W-1:0] REG_BAND_TOL    = 3'd3;
    localparam logic [IDX_W-1:0] REG_VOTES       = 3'd4;

    // register reset values
    localparam logic [LEVEL_W-1:0] RST_LEVEL_ONE   = 12'd1024;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_TWO   = 12'd2048;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_THREE = 12'd3071;
    localparam logic [LEVEL_W-1:0] RST_BAND_TOL    = 12'd372;
    localparam logic [VOTE_W-1:0]  RST_VOTES       = 3'd4;

    // key classes
    localparam logic [KEY_W-1:0] KEY_NONE  = 2'd0;
    localparam logic [KEY_W-1:0] KEY_ONE   = 2'd1;
    localparam logic [KEY_W-1:0] KEY_TWO   = 2'd2;
    localparam logic [KEY_W-1:0] KEY_THREE = 2'd3;

    // one key event beat
    typedef struct packed {
        logic [KEY_W-1:0] key_id;
        logic             pressed;
        logic             last_of_run;
    } ev_t;

    // events raised by one sample: up to two
    typedef struct packed {
        logic [1:0] count;
        ev_t        ev0;
        ev_t        ev1;
    } ev_pair_t;

endpackage

`default_nettype wire

[rtl/alkd_classify.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// alkd_classify: nearest key level within the band tolerance
// Pick the closest of three levels; ties go to the lower key, no match is 0.
// ---------------------------------------------------------------------------
module alkd_classify
    import alkd_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  wire logic [SAMPLE_BITS-1:0] code,
    input  wire logic [LEVEL_W-1:0]     level_one,
    input  wire logic [LEVEL_W-1:0]     level_two,
    input  wire logic [LEVEL_W-1:0]     level_three,
    input  wire logic [LEVEL_W-1:0]     band_tolerance,
    output logic      [KEY_W-1:0]       key_class
);

    localparam int CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

    logic [CMP_W-1:0] code_ext;
    logic [CMP_W-1:0] tol_ext;
    logic [CMP_W-1:0] lv [3];
    logic [CMP_W-1:0] delta [3];
    logic [2:0]       hit;
    logic [CMP_W-1:0] best_dist;

    assign code_ext = CMP_W'(code);
    assign tol_ext  = CMP_W'(band_tolerance);
    assign lv[0]    = CMP_W'(level_one);
    assign lv[1]    = CMP_W'(level_two);
    assign lv[2]    = CMP_W'(level_three);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            delta[k] = (code_ext >= lv[k]) ? (code_ext - lv[k]) : (lv[k] - code_ext);
            hit[k]   = (delta[k] <= tol_ext);
        end
    end

    // scan in key order; a later key wins only when strictly closer
    always_comb
    begin
        key_class = KEY_NONE;
        best_dist = delta[0];
        if (hit[0])
        begin
            key_class = KEY_ONE;
            best_dist = delta[0];
        end
        if (hit[1] && (key_class == KEY_NONE || delta[1] < best_dist))
        begin
            key_class = KEY_TWO;
            best_dist = delta[1];
        end
        if (hit[2] && (key_class == KEY_NONE || delta[2] < best_dist))
        begin
            key_class = KEY_THREE;
        end
    end

endmodule

`default_nettype wire

[rtl/alkd_vote.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// alkd_vote: class history ring and majority decision
// Hold the last samples' classes, pick the majority and raise key events.
// ---------------------------------------------------------------------------
module alkd_vote
    import alkd_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [KEY_W-1:0]  key_class,
    input  wire logic              link,
    input  wire logic [VOTE_W-1:0] votes_needed,
    output ev_pair_t               events
);

    localparam int POS_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int VC_W  = (CNT_W > VOTE_W) ? CNT_W : VOTE_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL     = CNT_W'(HISTORY_DEPTH);

    logic [KEY_W-1:0] ring_reg  [HISTORY_DEPTH];
    logic [KEY_W-1:0] ring_next [HISTORY_DEPTH];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [KEY_W-1:0] stable_key_reg, stable_key_next;

    logic [HISTORY_DEPTH-1:0] match [4];
    logic [CNT_W-1:0]         votes [4];
    logic [KEY_W-1:0]         winner;
    logic [CNT_W-1:0]         winner_votes;
    logic                     decide;

    // ring with the new class already in place
    always_comb
    begin
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            ring_next[i] = (pos_reg == POS_W'(i)) ? key_class : ring_reg[i];
        end
    end

    assign pos_next  = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
    assign fill_next = (fill_reg == FULL) ? fill_reg : fill_reg + 1'b1;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                match[c][i] = (ring_next[i] == KEY_W'(c));
            end
            votes[c] = CNT_W'($countones(match[c]));
        end
    end

    // strictly greater keeps the lowest class on a tie
    always_comb
    begin
        winner       = KEY_NONE;
        winner_votes = '0;
        for (int c = 0; c < 4; c++)
        begin
            if (votes[c] > winner_votes)
            begin
                winner       = KEY_W'(c);
                winner_votes = votes[c];
            end
        end
    end

    assign decide = (fill_next == FULL)
                 && (VC_W'(winner_votes) >= VC_W'(votes_needed))
                 && (winner != stable_key_reg);

    assign stable_key_next = decide ? winner : stable_key_reg;

    // up for the old key, then down for the new; drop both while link is down
    always_comb
    begin
        events = '0;
        if (step && decide && link)
        begin
            if (stable_key_reg != KEY_NONE && winner != KEY_NONE)
            begin
                events.count = 2'd2;
                events.ev0   = '{key_id: stable_key_reg, pressed: 1'b0, last_of_run: 1'b0};
                events.ev1   = '{key_id: winner, pressed: 1'b1, last_of_run: 1'b1};
            end
            else if (stable_key_reg != KEY_NONE)
            begin
                events.count = 2'd1;
                events.ev0   = '{key_id: stable_key_reg, pressed: 1'b0, last_of_run: 1'b1};
            end
            else
            begin
                events.count = 2'd1;
                events.ev0   = '{key_id: winner, pressed: 1'b1, last_of_run: 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                ring_reg[i] <= KEY_NONE;
            end
            pos_reg        <= '0;
            fill_reg       <= '0;
            stable_key_reg <= KEY_NONE;
        end
        else if (step)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                ring_reg[i] <= ring_next[i];
            end
            pos_reg        <= pos_next;
            fill_reg       <= fill_next;
            stable_key_reg <= stable_key_next;
        end
    end

    a_key_moves_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(stable_key_reg) |-> $past(step))
        else $error("stable key changed without a sample");

    a_key_moves_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(stable_key_reg) |-> (fill_reg == FULL))
        else $error("stable key changed before the ring filled");

    a_events_mean_change: assert property (@(posedge clk) disable iff (!rst_n)
        (events.count != 2'd0) |=> !$stable(stable_key_reg))
        else $error("event raised without a key change");

endmodule

`default_nettype wire

[rtl/alkd_evq.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// alkd_evq: four-entry event queue
// Take up to two event beats per cycle, hand out one per cycle while out_stall is low.
// ---------------------------------------------------------------------------
module alkd_evq
    import alkd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  ev_pair_t              events,
    output logic                  room,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic      [KEY_W-1:0] key_id,
    output logic                  pressed,
    output logic                  last_of_run
);

    localparam int QD    = 4;
    localparam int PTR_W = $clog2(QD);
    localparam int CNT_W = $clog2(QD + 1);

    ev_t              q_reg [QD];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] tail_plus1;
    logic             pop;
    ev_t              head_ev;

    assign room       = (count_reg <= CNT_W'(QD - 2));
    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && !out_stall;
    assign tail_plus1 = tail_reg + 1'b1;
    assign head_ev    = q_reg[head_reg];

    assign key_id      = head_ev.key_id;
    assign pressed     = head_ev.pressed;
    assign last_of_run = head_ev.last_of_run;

    assign head_next  = pop ? head_reg + 1'b1 : head_reg;
    assign tail_next  = tail_reg + PTR_W'(events.count);
    assign count_next = count_reg + CNT_W'(events.count) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (events.count != 2'd0)
        begin
            q_reg[tail_reg] <= events.ev0;
        end
        if (events.count == 2'd2)
        begin
            q_reg[tail_plus1] <= events.ev1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QD))
        else $error("event queue overflow");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (events.count != 2'd0) |-> room)
        else $error("events pushed without room");

endmodule

`default_nettype wire

[rtl/analog_ladder_key_debounce.sv]
`default_nettype none
// Path: an accepted sample beat waits in the input register until the event queue has room,
//   then its events are written into the queue and offered on out_valid in order.
// Throughput: one sample per cycle while the queue has room for two events; the events of a
//   sample leave one beat at a time, and the four-entry event queue sets how far input may
//   run ahead of output. Reset: rst_n is asynchronous, active low; it empties the pipeline
//   and queue, clears the class ring and the stable key, and resets the configuration registers.
// ---------------------------------------------------------------------------
// analog_ladder_key_debounce: resistor ladder keypad with majority debounce
// Classify each ADC sample to a key level, vote over recent samples, and
// emit up/down event beats when the debounced key changes.
// ---------------------------------------------------------------------------
module analog_ladder_key_debounce
    import alkd_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // APB configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [DATA_W-1:0]      pwdata,
    output logic      [DATA_W-1:0]      prdata,
    output logic                        pready,
    // sample channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [SAMPLE_BITS-1:0] adc_code,
    input  wire logic                   link_connected,
    // event channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [KEY_W-1:0]       key_id,
    output logic                        pressed,
    output logic                        last_of_run
);

    // configuration registers
    logic [LEVEL_W-1:0] level_one_reg;
    logic [LEVEL_W-1:0] level_two_reg;
    logic [LEVEL_W-1:0] level_three_reg;
    logic [LEVEL_W-1:0] band_tol_reg;
    logic [VOTE_W-1:0]  votes_reg;
    logic               cfg_write;
    logic [IDX_W-1:0]   cfg_idx;

    // input register stage
    logic                   s1_valid_reg, s1_valid_next;
    logic [SAMPLE_BITS-1:0] s1_code_reg;
    logic                   s1_link_reg;

    logic             in_take;
    logic             advance;
    logic             room;
    logic [KEY_W-1:0] key_class;
    ev_pair_t         events;

    // ---------------------------------------------------------------------
    // APB: zero wait states, byte address 4*index, unknown indexes ignored
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[IDX_W+1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_one_reg   <= RST_LEVEL_ONE;
            level_two_reg   <= RST_LEVEL_TWO;
            level_three_reg <= RST_LEVEL_THREE;
            band_tol_reg    <= RST_BAND_TOL;
            votes_reg       <= RST_VOTES;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_LEVEL_ONE:   level_one_reg   <= pwdata[LEVEL_W-1:0];
                REG_LEVEL_TWO:   level_two_reg   <= pwdata[LEVEL_W-1:0];
                REG_LEVEL_THREE: level_three_reg <= pwdata[LEVEL_W-1:0];
                REG_BAND_TOL:    band_tol_reg    <= pwdata[LEVEL_W-1:0];
                REG_VOTES:       votes_reg       <= pwdata[VOTE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_LEVEL_ONE:   prdata = DATA_W'(level_one_reg);
            REG_LEVEL_TWO:   prdata = DATA_W'(level_two_reg);
            REG_LEVEL_THREE: prdata = DATA_W'(level_three_reg);
            REG_BAND_TOL:    prdata = DATA_W'(band_tol_reg);
            REG_VOTES:       prdata = DATA_W'(votes_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Input stage: hold the sample until the queue can take two events.
    // Stall comes from registers only, so a new beat enters in the same
    // cycle the held one advances.
    // ---------------------------------------------------------------------
    assign advance  = s1_valid_reg && room;
    assign in_stall = s1_valid_reg && !room;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_code_reg <= adc_code;
            s1_link_reg <= link_connected;
        end
    end

    // ---------------------------------------------------------------------
    // Classify, vote and queue events in one pass after the input register
    // ---------------------------------------------------------------------
    alkd_classify #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_classify (
        .code           (s1_code_reg),
        .level_one      (level_one_reg),
        .level_two      (level_two_reg),
        .level_three    (level_three_reg),
        .band_tolerance (band_tol_reg),
        .key_class      (key_class)
    );

    alkd_vote #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_vote (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .key_class    (key_class),
        .link         (s1_link_reg),
        .votes_needed (votes_reg),
        .events       (events)
    );

    // one event beat per cycle toward the consumer while out_stall is low
    alkd_evq u_evq (
        .clk         (clk),
        .rst_n       (rst_n),
        .events      (events),
        .room        (room),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .key_id      (key_id),
        .pressed     (pressed),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

[dv/analog_ladder_key_debounce_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// analog_ladder_key_debounce_checker: key event predictor and scoreboard
// Follows register writes on the APB port, classifies and votes on every
// accepted sample beat, and compares each accepted event beat field by field
// with the oldest predicted event.
// ---------------------------------------------------------------------------
module analog_ladder_key_debounce_checker
    import alkd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic                   pready,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [DATA_W-1:0]      pwdata,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic [LEVEL_W-1:0]     adc_code,
    input  wire logic                   link_connected,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic [KEY_W-1:0]       key_id,
    input  wire logic                   pressed,
    input  wire logic                   last_of_run,
    output int                          mismatches,
    output int                          events_pending,
    output int                          samples_seen,
    output int                          events_seen
);

    // register copies, indexed by key number
    logic [LEVEL_W-1:0] key_level [1:3];
    logic [LEVEL_W-1:0] band_tol;
    logic [VOTE_W-1:0]  votes_needed;

    // debounce state
    logic [KEY_W-1:0]   class_ring [DEF_HISTORY_DEPTH];
    int                 ring_pos;
    int                 ring_fill;
    logic [KEY_W-1:0]   stable_key;

    ev_t                key_event_q [$];
    int                 fail_tally   = 0;
    int                 sample_tally = 0;
    int                 event_tally  = 0;

    function automatic void apply_write(input logic [IDX_W-1:0] idx,
                                        input logic [DATA_W-1:0] data);
        case (idx)
            REG_LEVEL_ONE:   key_level[1] = data[LEVEL_W-1:0];
            REG_LEVEL_TWO:   key_level[2] = data[LEVEL_W-1:0];
            REG_LEVEL_THREE: key_level[3] = data[LEVEL_W-1:0];
            REG_BAND_TOL:    band_tol     = data[LEVEL_W-1:0];
            REG_VOTES:       votes_needed = data[VOTE_W-1:0];
            default: ;
        endcase
    endfunction

    // nearest level within the band; the lower key keeps a tie
    function automatic logic [KEY_W-1:0] nearest_key(input logic [LEVEL_W-1:0] code);
        logic [KEY_W-1:0]   best;
        logic [LEVEL_W-1:0] best_dist;
        logic [LEVEL_W-1:0] delta;
        int                 k;
        best      = KEY_NONE;
        best_dist = '0;
        for (k = 1; k <= 3; k++)
        begin
            delta = (code >= key_level[k]) ? code - key_level[k] : key_level[k] - code;
            if (delta <= band_tol && (best == KEY_NONE || delta < best_dist))
            begin
                best      = k[KEY_W-1:0];
                best_dist = delta;
            end
        end
        return best;
    endfunction

    task automatic predict_sample(input logic [LEVEL_W-1:0] code, input logic link);
        int               votes [4];
        int               i;
        int               winner_votes;
        logic [KEY_W-1:0] winner;
        logic [KEY_W-1:0] prev;
        ev_t              ev;
        votes        = '{default: 0};
        winner       = KEY_NONE;
        winner_votes = 0;
        class_ring[ring_pos] = nearest_key(code);
        ring_pos = (ring_pos + 1) % DEF_HISTORY_DEPTH;
        if (ring_fill < DEF_HISTORY_DEPTH)
            ring_fill++;
        if (ring_fill == DEF_HISTORY_DEPTH)
        begin
            for (i = 0; i < DEF_HISTORY_DEPTH; i++)
                votes[class_ring[i]]++;
            // strict greater-than: lowest class keeps a vote tie
            for (i = 0; i < 4; i++)
            begin
                if (votes[i] > winner_votes)
                begin
                    winner       = i[KEY_W-1:0];
                    winner_votes = votes[i];
                end
            end
            if (winner_votes >= int'(votes_needed) && winner != stable_key)
            begin
                prev       = stable_key;
                stable_key = winner;
                if (link)
                begin
                    if (prev != KEY_NONE)
                    begin
                        ev.key_id      = prev;
                        ev.pressed     = 1'b0;
                        ev.last_of_run = (winner == KEY_NONE);
                        key_event_q.push_back(ev);
                    end
                    if (winner != KEY_NONE)
                    begin
                        ev.key_id      = winner;
                        ev.pressed     = 1'b1;
                        ev.last_of_run = 1'b1;
                        key_event_q.push_back(ev);
                    end
                end
            end
        end
    endtask

    task automatic check_event();
        ev_t want;
        event_tally++;
        if (key_event_q.size() == 0)
        begin
            $error("unexpected key event: key_id=%0d pressed=%0d last_of_run=%0d",
                   key_id, pressed, last_of_run);
            fail_tally++;
        end
        else
        begin
            want = key_event_q.pop_front();
            if (key_id !== want.key_id)
            begin
                $error("key_id: expected %0d, actual %0d", want.key_id, key_id);
                fail_tally++;
            end
            if (pressed !== want.pressed)
            begin
                $error("pressed: expected %0d, actual %0d", want.pressed, pressed);
                fail_tally++;
            end
            if (last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %0d, actual %0d", want.last_of_run, last_of_run);
                fail_tally++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_level[1] = RST_LEVEL_ONE;
            key_level[2] = RST_LEVEL_TWO;
            key_level[3] = RST_LEVEL_THREE;
            band_tol     = RST_BAND_TOL;
            votes_needed = RST_VOTES;
            foreach (class_ring[s])
                class_ring[s] = KEY_NONE;
            ring_pos   = 0;
            ring_fill  = 0;
            stable_key = KEY_NONE;
            key_event_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                apply_write(paddr[ADDR_W-1:2], pwdata);
            // events out now belong to earlier samples, so check before predicting
            if (out_valid && !out_stall)
                check_event();
            if (in_valid && !in_stall)
            begin
                sample_tally++;
                predict_sample(adc_code, link_connected);
            end
        end
        mismatches     <= fail_tally;
        events_pending <= key_event_q.size();
        samples_seen   <= sample_tally;
        events_seen    <= event_tally;
    end

endmodule

[dv/analog_ladder_key_debounce_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// analog_ladder_key_debounce_tb: top of the ladder keypad debounce bench
// Drives ADC sample beats and register writes, stalls the event channel at
// random, and gives the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module analog_ladder_key_debounce_tb
    import alkd_pkg::*;
();

    localparam int                 CYCLE_LIMIT  = 300000;
    localparam int                 DRAIN_CYCLES = 8;     // margin for samples that raise no event
    localparam int                 HOLD_CYCLES  = 300;   // long event-side hold-off
    localparam logic [LEVEL_W-1:0] MAX_CODE     = '1;
    localparam logic [IDX_W-1:0]   REG_UNMAPPED = 3'd5;  // first index past the map

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [DATA_W-1:0]      pwdata;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_stall;
    logic [LEVEL_W-1:0]     adc_code;
    logic                   link_connected;
    logic                   out_valid;
    logic                   out_stall;
    logic [KEY_W-1:0]       key_id;
    logic                   pressed;
    logic                   last_of_run;

    int                     mismatches;
    int                     events_pending;
    int                     samples_seen;
    int                     events_seen;

    // levels and band the stimulus aims at, kept as the block masks them
    logic [LEVEL_W-1:0]     level_of [1:3];
    logic [LEVEL_W-1:0]     tol_now;
    int                     settings_used = 1;
    bit                     no_idle       = 1'b0;
    bit                     long_hold_req = 1'b0;
    int                     cycle_count   = 0;

    analog_ladder_key_debounce dut (.*);

    analog_ladder_key_debounce_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: end the run if it hangs on a handshake.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Event-side receiver: draw a random stall before each beat, or none while the
    // no-idle stretch is on. A pending long hold-off takes priority and keeps stall
    // high long enough for the event queue to back up into the sample channel.
    initial
    begin : event_sink
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            hold = no_idle ? 0 : $urandom_range(0, 4);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            // wait for one beat to go through, or break off for a hold-off
            @(posedge clk);
            while (!out_valid && !long_hold_req)
                @(posedge clk);
        end
    end

    // One APB write: setup, access until pready, then idle with psel low so a
    // following write never lowers and raises psel in the same step.
    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, let every predicted event come out, then give the block
    // time to finish samples that raise no event.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (events_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all five registers while idle; values may carry junk upper bits.
    task automatic apply_setting(input logic [DATA_W-1:0] l1, input logic [DATA_W-1:0] l2,
                                 input logic [DATA_W-1:0] l3, input logic [DATA_W-1:0] tol,
                                 input logic [DATA_W-1:0] votes);
        wait_drained();
        reg_write(REG_LEVEL_ONE, l1);
        reg_write(REG_LEVEL_TWO, l2);
        reg_write(REG_LEVEL_THREE, l3);
        reg_write(REG_BAND_TOL, tol);
        reg_write(REG_VOTES, votes);
        level_of[1] = l1[LEVEL_W-1:0];
        level_of[2] = l2[LEVEL_W-1:0];
        level_of[3] = l3[LEVEL_W-1:0];
        tol_now     = tol[LEVEL_W-1:0];
        settings_used++;
    endtask

    // Offer one sample beat after a random gap and hold it until accepted.
    task automatic send_sample(input logic [LEVEL_W-1:0] code, input logic link);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        adc_code       <= code;
        link_connected <= link;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_run(input logic [LEVEL_W-1:0] code, input logic link, input int count);
        repeat (count) send_sample(code, link);
    endtask

    // A code that should land on the given key: dead center, either band
    // edge, or anywhere inside the band. Key none is any code at all.
    function automatic logic [LEVEL_W-1:0] sample_near(input logic [KEY_W-1:0] key);
        int center;
        int offset;
        int code;
        if (key == KEY_NONE)
            return LEVEL_W'($urandom_range(0, MAX_CODE));
        center = int'(level_of[key]);
        case ($urandom_range(0, 3))
            0:       offset = 0;
            1:       offset = int'(tol_now);
            2:       offset = -int'(tol_now);
            default: offset = $urandom_range(0, tol_now) * ($urandom_range(0, 1) ? 1 : -1);
        endcase
        code = center + offset;
        if (code < 0)
            code = 0;
        if (code > int'(MAX_CODE))
            code = int'(MAX_CODE);
        return code[LEVEL_W-1:0];
    endfunction

    // Mostly runs of one key with the odd glitch sample, so the vote actually
    // settles and events fire; the rest is single random codes.
    task automatic random_traffic(input int n);
        int               sent;
        int               run_len;
        logic [KEY_W-1:0] key;
        logic             link;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 15) == 0)
                no_idle = !no_idle;
            if ($urandom_range(0, 99) < 85)
            begin
                key     = KEY_W'($urandom_range(0, 3));
                run_len = $urandom_range(3, 8);
                link    = ($urandom_range(0, 7) != 0);
                repeat (run_len)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_sample(LEVEL_W'($urandom_range(0, MAX_CODE)), link);
                    else
                        send_sample(sample_near(key), link);
                end
                sent += run_len;
            end
            else
            begin
                send_sample(LEVEL_W'($urandom_range(0, MAX_CODE)), ($urandom_range(0, 1) != 0));
                sent++;
            end
        end
    endtask

    initial
    begin
        // every input known from time zero
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        adc_code       = '0;
        link_connected = 1'b0;
        level_of[1]    = RST_LEVEL_ONE;
        level_of[2]    = RST_LEVEL_TWO;
        level_of[3]    = RST_LEVEL_THREE;
        tol_now        = RST_BAND_TOL;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, directed: code extremes, band edges on both sides of
        // key one, then whole runs that press, silently switch (link down),
        // switch with up+down, and release to no key.
        send_sample('0, 1'b1);
        send_sample(MAX_CODE, 1'b1);
        send_sample(RST_LEVEL_ONE - RST_BAND_TOL - 12'd1, 1'b1);
        send_sample(RST_LEVEL_ONE + RST_BAND_TOL, 1'b1);
        send_sample(RST_LEVEL_ONE - RST_BAND_TOL, 1'b1);
        send_run(RST_LEVEL_ONE, 1'b1, 5);
        send_run(RST_LEVEL_TWO, 1'b0, 5);
        send_run(RST_LEVEL_THREE, 1'b1, 5);
        send_run(MAX_CODE, 1'b1, 5);
        random_traffic(300);

        // Coinciding levels one and two, full tolerance, single vote: every
        // code matches, three-way distance ties go to key one.
        apply_setting(2000, 2000, 2100, DATA_W'(MAX_CODE), 1);
        send_sample(12'd2050, 1'b1);
        send_sample(12'd2000, 1'b1);
        send_sample(12'd2100, 1'b1);
        send_sample('0, 1'b1);
        send_sample(MAX_CODE, 1'b1);
        random_traffic(200);

        // Levels at both ends of the range, zero tolerance, all five votes.
        apply_setting(0, DATA_W'(MAX_CODE), 2047, 0, 5);
        random_traffic(200);

        // Zero vote threshold: the majority always wins.
        apply_setting($urandom_range(0, MAX_CODE), $urandom_range(0, MAX_CODE),
                      $urandom_range(0, MAX_CODE), 100, 0);
        random_traffic(200);

        // Oversized values get masked; a threshold of seven can never be met,
        // and a write past the register map must change nothing.
        apply_setting(32'hFFFF_F123, 1500, 3500, 300, 32'hFFFF_FFFF);
        reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        random_traffic(150);

        // Back-pressure: hold the event side off while samples keep coming.
        apply_setting(DATA_W'(RST_LEVEL_ONE), DATA_W'(RST_LEVEL_TWO),
                      DATA_W'(RST_LEVEL_THREE), DATA_W'(RST_BAND_TOL), DATA_W'(RST_VOTES));
        long_hold_req = 1'b1;
        random_traffic(100);

        // Random settings with junk in the unused upper bits.
        repeat (4)
        begin
            apply_setting($urandom(), $urandom(), $urandom(),
                          ($urandom() & ~32'hFFF) | $urandom_range(0, 600),
                          ($urandom() & ~32'h7) | $urandom_range(1, 5));
            random_traffic(110);
        end

        wait_drained();
        $display("tb: %0d samples over %0d register settings, %0d key event beats compared",
                 samples_seen, settings_used, events_seen);
        $display("tb: covered masking, unmapped writes, vote thresholds 0..7, long hold-off");
        if (mismatches == 0 && events_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
